/* rtl/tedwr_pkg.sv */
package tedwr_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int ROLL_W  = 2;
    localparam int UNIT_W  = 2;
    localparam int COUNT_W = 7;
    localparam int CIDX_W  = 2;
    localparam int CDATA_W = 7;
    localparam int ACC_W   = 16;
    localparam int YMOD_W  = 9;

    localparam logic [CIDX_W-1:0] CFG_TENOR_UNIT  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_TENOR_COUNT = 2'd1;

    localparam logic [UNIT_W-1:0] UNIT_DAY   = 2'd0;
    localparam logic [UNIT_W-1:0] UNIT_WEEK  = 2'd1;
    localparam logic [UNIT_W-1:0] UNIT_MONTH = 2'd2;
    localparam logic [UNIT_W-1:0] UNIT_YEAR  = 2'd3;

    localparam logic [ACC_W-1:0]  YEAR_CYCLE = 16'd400;
    localparam logic [YMOD_W-1:0] YMOD_LAST  = 9'd399;
    localparam logic [2:0]        WD_SUN     = 3'd0;
    localparam logic [2:0]        WD_SAT     = 3'd6;
    localparam logic [ROLL_W-1:0] ROLL_MAX   = 2'd2;
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    typedef struct packed {
        logic [UNIT_W-1:0]  unit;
        logic [COUNT_W-1:0] count;
    } cfg_t;

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } date_t;

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic [ROLL_W-1:0]  rolled;
    } res_t;

    function automatic logic [8:0] unit_days(input logic [UNIT_W-1:0] u);
        logic [8:0] r;
        case (u)
            UNIT_DAY:   r = 9'd1;
            UNIT_WEEK:  r = 9'd7;
            UNIT_MONTH: r = 9'd31;
            UNIT_YEAR:  r = 9'd365;
            default:    r = 9'd1;
        endcase
        return r;
    endfunction

    function automatic logic is_leap(input logic [YMOD_W-1:0] ymod);
        return (ymod[1:0] == 2'd0) && (ymod != 9'd100) && (ymod != 9'd200)
               && (ymod != 9'd300);
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] r;
        case (m)
            4'd2:    r = leap ? 5'd29 : 5'd28;
            4'd4:    r = 5'd30;
            4'd6:    r = 5'd30;
            4'd9:    r = 5'd30;
            4'd11:   r = 5'd30;
            default: r = 5'd31;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] month_offset(input logic [MONTH_W-1:0] m);
        logic [2:0] r;
        case (m)
            4'd1:    r = 3'd0;
            4'd2:    r = 3'd3;
            4'd3:    r = 3'd2;
            4'd4:    r = 3'd5;
            4'd5:    r = 3'd0;
            4'd6:    r = 3'd3;
            4'd7:    r = 3'd5;
            4'd8:    r = 3'd1;
            4'd9:    r = 3'd4;
            4'd10:   r = 3'd6;
            4'd11:   r = 3'd2;
            4'd12:   r = 3'd4;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] mod7(input logic [7:0] x);
        logic [13:0] p;
        logic [5:0]  q;
        logic [7:0]  r;
        p = 14'(x) * 14'd36;
        q = p[13:8];
        r = x - 8'(q) * 8'd7;
        if (r >= 8'd7)
            r = r - 8'd7;
        return r[2:0];
    endfunction

    // 400-year part drops out: 497 * (yy / 400) is a multiple of 7
    function automatic logic [2:0] weekday(input logic [DAY_W-1:0] d,
                                           input logic [MONTH_W-1:0] m,
                                           input logic [YMOD_W-1:0] ymod);
        logic [YMOD_W-1:0] yr;
        logic [1:0]        b;
        logic [YMOD_W-1:0] c9;
        logic [6:0]        c;
        logic [7:0]        s;
        if (m < MONTH_MAR)
            yr = (ymod == 9'd0) ? YMOD_LAST : ymod - 9'd1;
        else
            yr = ymod;
        if (yr >= 9'd300)
        begin
            b  = 2'd3;
            c9 = yr - 9'd300;
        end
        else if (yr >= 9'd200)
        begin
            b  = 2'd2;
            c9 = yr - 9'd200;
        end
        else if (yr >= 9'd100)
        begin
            b  = 2'd1;
            c9 = yr - 9'd100;
        end
        else
        begin
            b  = 2'd0;
            c9 = yr;
        end
        c = c9[6:0];
        s = 8'(c) + 8'(c[6:2]) + 8'(b) * 8'd5 + 8'(month_offset(m)) + 8'(d);
        return mod7(s);
    endfunction

endpackage

/* rtl/tenor_end_date_weekend_roll.sv */
// channel  direction  handshake                 payload
// in       to block   in_valid / in_stall       start_day, start_month, start_year
// out      from block out_valid / out_stall     end_day, end_month, end_year,
//                                               weekend_days_rolled
// cfg      to block   cfg_valid / cfg_ready     cfg_index, cfg_data
//
// An item reduces start_year modulo 400, then carries the day count across the months crossed,
// then takes weekend steps (0 to 2), each followed by another carry; those steps share one subtractor.
// Reset clears tenor_unit to day and tenor_count to 1; no clearing sweep.
// in_stall is high while an item is at work; the next item enters once it finishes.
// A result waits in the output register under out_stall while the next item runs.
module tenor_end_date_weekend_roll
    import tedwr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [DAY_W-1:0]   start_day,
    input  logic [MONTH_W-1:0] start_month,
    input  logic [YEAR_W-1:0]  start_year,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [DAY_W-1:0]   end_day,
    output logic [MONTH_W-1:0] end_month,
    output logic [YEAR_W-1:0]  end_year,
    output logic [ROLL_W-1:0]  weekend_days_rolled,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CIDX_W-1:0]  cfg_index,
    input  logic [CDATA_W-1:0] cfg_data
);

    cfg_t  cfg_reg;
    date_t start;
    res_t  res;
    res_t  out_reg;
    logic  out_valid_reg;
    logic  busy, res_valid, res_take, go;

    assign cfg_ready = 1'b1;
    assign in_stall  = busy;
    assign go        = in_valid && !busy;
    assign res_take  = res_valid && (!out_valid_reg || !out_stall);

    assign start.day   = start_day;
    assign start.month = start_month;
    assign start.year  = start_year;

    tedwr_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .go        (go),
        .start     (start),
        .busy      (busy),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.unit  <= '0;
            cfg_reg.count <= 7'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_TENOR_UNIT:  cfg_reg.unit  <= cfg_data[UNIT_W-1:0];
                CFG_TENOR_COUNT: cfg_reg.count <= cfg_data[COUNT_W-1:0];
                default:         cfg_reg       <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_take)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
            out_reg <= res;
    end

    assign out_valid           = out_valid_reg;
    assign end_day             = out_reg.day;
    assign end_month           = out_reg.month;
    assign end_year            = out_reg.year;
    assign weekend_days_rolled = out_reg.rolled;

endmodule

/* rtl/tedwr_alu.sv */
module tedwr_alu
    import tedwr_pkg::*;
(
    input  logic [ACC_W-1:0] a,
    input  logic [ACC_W-1:0] b,
    output logic [ACC_W-1:0] diff,
    output logic             ge,
    output logic             gt
);

    logic [ACC_W:0] wide;

    assign wide = {1'b0, a} - {1'b0, b};
    assign diff = wide[ACC_W-1:0];
    assign ge   = ~wide[ACC_W];
    assign gt   = ge && (diff != '0);

endmodule

/* rtl/tedwr_core.sv */
module tedwr_core
    import tedwr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  logic  go,
    input  date_t start,
    output logic  busy,
    output logic  res_valid,
    input  logic  res_take,
    output res_t  res
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_CARRY,
        S_WDAY,
        S_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [ACC_W-1:0]    d_reg, d_next;
    logic [MONTH_W-1:0]  m_reg, m_next;
    logic [YEAR_W:0]     y_reg, y_next;
    logic [YEAR_W-1:0]   rem_reg, rem_next;
    logic [YMOD_W-1:0]   ymod_reg, ymod_next;
    logic [ROLL_W-1:0]   rolled_reg, rolled_next;

    logic [ACC_W-1:0]    alu_a, alu_b, alu_diff;
    logic                alu_ge, alu_gt;
    logic [DAY_W-1:0]    mdays;
    logic [2:0]          wd;
    logic [ACC_W-1:0]    tenor_days;
    logic [DAY_W-1:0]    d0;
    logic [MONTH_W-1:0]  m0;

    tedwr_alu u_alu (
        .a    (alu_a),
        .b    (alu_b),
        .diff (alu_diff),
        .ge   (alu_ge),
        .gt   (alu_gt)
    );

    assign mdays      = month_len(m_reg, is_leap(ymod_reg));
    assign wd         = weekday(d_reg[DAY_W-1:0], m_reg, ymod_reg);
    assign tenor_days = ACC_W'(cfg.count) * ACC_W'(unit_days(cfg.unit));
    assign d0         = (start.day == '0) ? 5'd1 : start.day;
    assign m0         = (start.month == '0) ? MONTH_JAN :
                        (start.month > MONTH_DEC) ? MONTH_DEC : start.month;

    always_comb
    begin
        if (state_reg == S_MOD)
        begin
            alu_a = ACC_W'(rem_reg);
            alu_b = YEAR_CYCLE;
        end
        else
        begin
            alu_a = d_reg;
            alu_b = ACC_W'(mdays);
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        d_next      = d_reg;
        m_next      = m_reg;
        y_next      = y_reg;
        rem_next    = rem_reg;
        ymod_next   = ymod_reg;
        rolled_next = rolled_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (go)
                begin
                    d_next      = ACC_W'(d0) + tenor_days;
                    m_next      = m0;
                    y_next      = {1'b0, start.year};
                    rem_next    = start.year;
                    rolled_next = '0;
                    state_next  = S_MOD;
                end
            end
            S_MOD:
            begin
                if (alu_ge)
                    rem_next = alu_diff[YEAR_W-1:0];
                else
                begin
                    ymod_next  = rem_reg[YMOD_W-1:0];
                    state_next = S_CARRY;
                end
            end
            S_CARRY:
            begin
                if (alu_gt)
                begin
                    d_next = alu_diff;
                    if (m_reg >= MONTH_DEC)
                    begin
                        m_next    = MONTH_JAN;
                        y_next    = y_reg + 1'b1;
                        ymod_next = (ymod_reg == YMOD_LAST) ? '0 : ymod_reg + 1'b1;
                    end
                    else
                        m_next = m_reg + 1'b1;
                end
                else
                    state_next = S_WDAY;
            end
            S_WDAY:
            begin
                if ((wd == WD_SUN || wd == WD_SAT) && rolled_reg < ROLL_MAX)
                begin
                    d_next      = d_reg + 1'b1;
                    rolled_next = rolled_reg + 1'b1;
                    state_next  = S_CARRY;
                end
                else
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_take)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            rolled_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            rolled_reg <= rolled_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg    <= d_next;
        m_reg    <= m_next;
        y_reg    <= y_next;
        rem_reg  <= rem_next;
        ymod_reg <= ymod_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res.day    = d_reg[DAY_W-1:0];
    assign res.month  = m_reg;
    assign res.year   = y_reg[YEAR_W-1:0];
    assign res.rolled = rolled_reg;

    a_ymod_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CARRY || state_reg == S_WDAY || state_reg == S_DONE)
        |-> ymod_reg <= YMOD_LAST)
        else $error("year remainder out of range");

    a_done_date: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |-> (d_reg >= 16'd1 && d_reg <= ACC_W'(mdays)
        && m_reg >= MONTH_JAN && m_reg <= MONTH_DEC))
        else $error("finished date not normalized");

    a_roll_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WDAY && state_next == S_CARRY)
        |=> rolled_reg == $past(rolled_reg) + 1'b1 && d_reg == $past(d_reg) + 1'b1)
        else $error("weekend step lost");

    a_roll_limit: assert property (@(posedge clk) disable iff (!rst_n)
        rolled_reg <= ROLL_MAX)
        else $error("too many weekend steps");

endmodule

/* tb/sv/tenor_end_date_weekend_roll_tb.sv */
module tenor_end_date_weekend_roll_tb;
    import tedwr_pkg::*;

    localparam logic [CIDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS   = 460;
    localparam int QUIET_TAIL     = 40;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 60;

    class end_date_board;
        logic [UNIT_W-1:0]  unit;
        logic [COUNT_W-1:0] count;
        res_t               end_dates_q[$];
        int                 errors;
        int                 checked;
        int                 rolls;

        function new();
            unit    = UNIT_DAY;
            count   = 7'd1;
            errors  = 0;
            checked = 0;
            rolls   = 0;
        endfunction

        function void set_reg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] val);
            if (idx == CFG_TENOR_UNIT)
                unit = val[UNIT_W-1:0];
            else if (idx == CFG_TENOR_COUNT)
                count = val[COUNT_W-1:0];
        endfunction

        function int unsigned days_in(input int unsigned m, input int unsigned y);
            int unsigned n;
            bit          leap;
            leap = ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
            case (m)
                2:           n = leap ? 29 : 28;
                4, 6, 9, 11: n = 30;
                default:     n = 31;
            endcase
            return n;
        endfunction

        // 0 is Sunday; the year is lifted by 400 to stay non-negative
        function int unsigned day_of_week(input int unsigned d, input int unsigned m,
                                          input int unsigned y);
            int unsigned yy;
            int unsigned shift;
            case (m)
                1:       shift = 0;
                2:       shift = 3;
                3:       shift = 2;
                4:       shift = 5;
                5:       shift = 0;
                6:       shift = 3;
                7:       shift = 5;
                8:       shift = 1;
                9:       shift = 4;
                10:      shift = 6;
                11:      shift = 2;
                default: shift = 4;
            endcase
            yy = y + 400 - ((m < MONTH_MAR) ? 1 : 0);
            return (yy + yy / 4 - yy / 100 + yy / 400 + shift + d) % 7;
        endfunction

        function void carry_months(inout int unsigned d, inout int unsigned m,
                                   inout int unsigned y);
            while (d > days_in(m, y))
            begin
                d -= days_in(m, y);
                if (m >= MONTH_DEC)
                begin
                    m = 32'(MONTH_JAN);
                    y++;
                end
                else
                    m++;
            end
        endfunction

        function res_t roll_forward(input logic [DAY_W-1:0] sd, input logic [MONTH_W-1:0] sm,
                                    input logic [YEAR_W-1:0] sy);
            int unsigned d;
            int unsigned m;
            int unsigned y;
            int unsigned span;
            int unsigned n;
            int unsigned wd;
            res_t        r;
            d = (sd == '0) ? 32'd1 : 32'(sd);
            m = 32'((sm == '0) ? MONTH_JAN : ((sm > MONTH_DEC) ? MONTH_DEC : sm));
            y = 32'(sy);
            case (unit)
                UNIT_DAY:   span = 1;
                UNIT_WEEK:  span = 7;
                UNIT_MONTH: span = 31;
                default:    span = 365;
            endcase
            d += 32'(count) * span;
            carry_months(d, m, y);
            n  = 0;
            wd = day_of_week(d, m, y);
            while ((wd == WD_SUN || wd == WD_SAT) && n < ROLL_MAX)
            begin
                d++;
                carry_months(d, m, y);
                n++;
                wd = day_of_week(d, m, y);
            end
            r.day    = d[DAY_W-1:0];
            r.month  = m[MONTH_W-1:0];
            r.year   = y[YEAR_W-1:0];
            r.rolled = n[ROLL_W-1:0];
            return r;
        endfunction

        function void note_start(input logic [DAY_W-1:0] sd, input logic [MONTH_W-1:0] sm,
                                 input logic [YEAR_W-1:0] sy);
            end_dates_q.push_back(roll_forward(sd, sm, sy));
        endfunction

        function void check_end(input res_t got);
            res_t want;
            if (end_dates_q.size() == 0)
            begin
                $error("end date %0d-%0d-%0d with no start date pending",
                       got.year, got.month, got.day);
                errors++;
                return;
            end
            want = end_dates_q.pop_front();
            checked++;
            if (want.rolled != 0)
                rolls++;
            if (got.day != want.day)
            begin
                $error("end_day: expected %0d, actual %0d", want.day, got.day);
                errors++;
            end
            if (got.month != want.month)
            begin
                $error("end_month: expected %0d, actual %0d", want.month, got.month);
                errors++;
            end
            if (got.year != want.year)
            begin
                $error("end_year: expected %0d, actual %0d", want.year, got.year);
                errors++;
            end
            if (got.rolled != want.rolled)
            begin
                $error("weekend_days_rolled: expected %0d, actual %0d",
                       want.rolled, got.rolled);
                errors++;
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [DAY_W-1:0]   start_day = '0;
    logic [MONTH_W-1:0] start_month = '0;
    logic [YEAR_W-1:0]  start_year = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [DAY_W-1:0]   end_day;
    logic [MONTH_W-1:0] end_month;
    logic [YEAR_W-1:0]  end_year;
    logic [ROLL_W-1:0]  weekend_days_rolled;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CIDX_W-1:0]  cfg_index = '0;
    logic [CDATA_W-1:0] cfg_data = '0;

    end_date_board board;
    int            sent = 0;
    int            settings = 1;
    int            stall_left = 0;
    int            idle_cycles = 0;
    bit            quiet = 1'b0;

    tenor_end_date_weekend_roll dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .start_day           (start_day),
        .start_month         (start_month),
        .start_year          (start_year),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .end_day             (end_day),
        .end_month           (end_month),
        .end_year            (end_year),
        .weekend_days_rolled (weekend_days_rolled),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                board.note_start(start_day, start_month, start_year);
            if (out_valid && !out_stall)
                board.check_end(res_t'({end_day, end_month, end_year, weekend_days_rolled}));
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("** tenor_end_date_weekend_roll: FAILED **");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // hold the result side off in short bursts
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (!quiet && $urandom_range(0, 5) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 3);
        end
        else
            out_stall <= 1'b0;
    end

    task automatic send_date(input logic [DAY_W-1:0] d, input logic [MONTH_W-1:0] m,
                             input logic [YEAR_W-1:0] y);
        @(negedge clk);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_valid    <= 1'b1;
        start_day   <= d;
        start_month <= m;
        start_year  <= y;
        sent++;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_random;
        logic [MONTH_W-1:0] m;
        if ($urandom_range(0, 7) == 0)
            send_date(DAY_W'($urandom_range(0, 31)), MONTH_W'($urandom_range(0, 15)),
                      YEAR_W'($urandom_range(0, 16383)));
        else
        begin
            m = MONTH_W'($urandom_range(1, 12));
            send_date(DAY_W'($urandom_range(1, board.days_in(32'(m), 2000))), m,
                      YEAR_W'($urandom_range(1, 9999)));
        end
    endtask

    // drop valid and wait out every pending end date
    task automatic drain;
        @(negedge clk);
        in_valid <= 1'b0;
        while (board.end_dates_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.set_reg(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_tenor(input logic [UNIT_W-1:0] u, input logic [COUNT_W-1:0] c);
        drain();
        write_reg(CFG_TENOR_UNIT, CDATA_W'(u));
        write_reg(CFG_TENOR_COUNT, CDATA_W'(c));
        settings++;
    endtask

    initial
    begin
        int                 target;
        int                 n;
        logic [UNIT_W-1:0]  u;
        logic [COUNT_W-1:0] c;

        board = new();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_date(5'd31, 4'd12, 14'd16383);
        send_date(5'd0, 4'd0, 14'd0);
        send_date(5'd28, 4'd2, 14'd2000);
        send_date(5'd28, 4'd2, 14'd1900);
        send_date(5'd28, 4'd2, 14'd2024);
        send_date(5'd31, 4'd4, 14'd2023);
        send_date(5'd15, 4'd13, 14'd9999);
        send_date(5'd1, 4'd15, 14'd1);
        send_date(5'd5, 4'd1, 14'd2024);
        send_date(5'd6, 4'd1, 14'd2024);

        set_tenor(UNIT_DAY, 7'd2);
        send_date(5'd5, 4'd1, 14'd2024);
        set_tenor(UNIT_DAY, 7'd3);
        send_date(5'd4, 4'd1, 14'd2024);
        set_tenor(UNIT_DAY, 7'd0);
        send_date(5'd6, 4'd1, 14'd2024);
        send_date(5'd7, 4'd1, 14'd2024);
        set_tenor(UNIT_WEEK, 7'd1);
        send_date(5'd1, 4'd1, 14'd1);
        set_tenor(UNIT_MONTH, 7'd1);
        send_date(5'd31, 4'd1, 14'd2024);
        set_tenor(UNIT_YEAR, 7'd1);
        send_date(5'd29, 4'd2, 14'd2024);
        set_tenor(UNIT_YEAR, 7'd127);
        send_date(5'd31, 4'd12, 14'd16383);
        send_date(5'd0, 4'd0, 14'd0);
        set_tenor(UNIT_MONTH, 7'd100);
        send_date(5'd15, 4'd6, 14'd9999);
        drain();
        write_reg(CFG_UNUSED, 7'h7F);
        send_date(5'd1, 4'd3, 14'd2000);

        target = sent + RANDOM_ITEMS;
        while (sent < target)
        begin
            u = UNIT_W'($urandom_range(0, 3));
            case ($urandom_range(0, 9))
                0:
                begin
                    c = COUNT_W'($urandom_range(64, 127));
                    n = 3;
                end
                1, 2:
                begin
                    c = COUNT_W'($urandom_range(0, 3));
                    n = 30;
                end
                default:
                begin
                    c = COUNT_W'($urandom_range(0, 20));
                    n = $urandom_range(20, 40);
                end
            endcase
            set_tenor(u, c);
            for (int i = 0; i < n && sent < target; i++)
            begin
                quiet = (sent >= target - QUIET_TAIL);
                send_random();
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d end dates checked over %0d tenor settings,", board.checked, settings);
        $display("%0d of them rolled off a weekend", board.rolls);
        if (board.errors == 0 && board.end_dates_q.size() == 0)
            $display("** tenor_end_date_weekend_roll: PASSED **");
        else
            $display("** tenor_end_date_weekend_roll: FAILED **");
        $finish;
    end

endmodule

/* files.f */
rtl/tedwr_pkg.sv
rtl/tedwr_alu.sv
rtl/tedwr_core.sv
rtl/tenor_end_date_weekend_roll.sv
tb/sv/tenor_end_date_weekend_roll_tb.sv
